// ----- sv/ipv4_flow_accounting_table_macros.svh -----
// Assertion macros shared by the checker.
`ifndef IPV4_FLOW_ACCOUNTING_TABLE_MACROS_SVH
`define IPV4_FLOW_ACCOUNTING_TABLE_MACROS_SVH

// Assert an implication on the rising clock edge, off during reset.
`define FAT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Assert an implication whose consequent is checked at the next clock edge.
`define FAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/fat_pkg.sv -----
package fat_pkg;

	localparam int unsigned PosW = 16;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_NEW     = 2'd1,
		ST_UPDATE  = 2'd2,
		ST_EVICT   = 2'd3
	} status_t;

	localparam logic [15:0] EtherIpv4 = 16'h0800;
	localparam logic [3:0]  IhlPlain  = 4'd5;
	localparam logic [7:0]  ProtoTcp  = 8'd6;
	localparam logic [7:0]  ProtoUdp  = 8'd17;
	localparam logic [15:0] MinEth    = 16'd14;
	localparam logic [15:0] MinIp     = 16'd34;
	localparam logic [15:0] MinTcp    = 16'd54;
	localparam logic [15:0] MinUdp    = 16'd42;

	// Client-oriented flow key.
	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] cip;
		logic [31:0] rip;
		logic [31:0] ports;
		logic [7:0]  proto;
	} flow_key_t;

	// One finished frame handed from the parser to the table.
	typedef struct packed {
		logic        counted;
		logic        dir;
		logic [15:0] len;
		logic [63:0] now;
		flow_key_t   key;
	} frame_info_t;

	typedef struct packed {
		logic [63:0] packets;
		logic [63:0] upload;
		logic [63:0] download;
		logic [63:0] first_seen;
		logic [63:0] last_seen;
	} flow_stats_t;

endpackage

// ----- sv/fat_parser.sv -----
module fat_parser
	import fat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        beat,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	input  logic        direction,
	input  logic [63:0] time_ns,
	output logic        frame_done,
	output frame_info_t frame
);

	logic [PosW-1:0] pos_q;
	logic            dir_q;
	logic [47:0]     dmac_q, smac_q;
	logic [15:0]     etype_q;
	logic [7:0]      vihl_q, proto_q;
	logic [31:0]     sip_q, dip_q;
	logic [15:0]     sport_q, dport_q;

	logic [47:0] dmac_n, smac_n;
	logic [15:0] etype_n, sport_n, dport_n, len;
	logic [7:0]  vihl_n, proto_n;
	logic [31:0] sip_n, dip_n;
	logic        dir_n, ok;

	always_comb begin
		dmac_n  = dmac_q;
		smac_n  = smac_q;
		etype_n = etype_q;
		vihl_n  = vihl_q;
		proto_n = proto_q;
		sip_n   = sip_q;
		dip_n   = dip_q;
		sport_n = sport_q;
		dport_n = dport_q;
		dir_n   = (pos_q == '0) ? direction : dir_q;
		if (pos_q < 16'd6)
			dmac_n = {dmac_q[39:0], data_byte};
		else if (pos_q < 16'd12)
			smac_n = {smac_q[39:0], data_byte};
		else if (pos_q < 16'd14)
			etype_n = {etype_q[7:0], data_byte};
		else if (pos_q == 16'd14)
			vihl_n = data_byte;
		else if (pos_q == 16'd23)
			proto_n = data_byte;
		else if (pos_q >= 16'd26 && pos_q < 16'd30)
			sip_n = {sip_q[23:0], data_byte};
		else if (pos_q >= 16'd30 && pos_q < 16'd34)
			dip_n = {dip_q[23:0], data_byte};
		else if (pos_q >= 16'd34 && pos_q < 16'd36)
			sport_n = {sport_q[7:0], data_byte};
		else if (pos_q >= 16'd36 && pos_q < 16'd38)
			dport_n = {dport_q[7:0], data_byte};

		len = (pos_q == 16'hFFFF) ? 16'hFFFF : pos_q + 16'd1;
		ok = (len >= MinEth) && (etype_n == EtherIpv4) && (len >= MinIp)
			&& (vihl_n[3:0] == IhlPlain)
			&& (((proto_n == ProtoTcp) && (len >= MinTcp))
			|| ((proto_n == ProtoUdp) && (len >= MinUdp)));

		frame_done    = beat && end_of_packet;
		frame.counted = ok;
		frame.dir     = dir_n;
		frame.len     = len;
		frame.now     = time_ns;
		if (!dir_n) begin
			frame.key.mac   = smac_n;
			frame.key.cip   = sip_n;
			frame.key.rip   = dip_n;
			frame.key.ports = {sport_n, dport_n};
		end else begin
			frame.key.mac   = dmac_n;
			frame.key.cip   = dip_n;
			frame.key.rip   = sip_n;
			frame.key.ports = {dport_n, sport_n};
		end
		frame.key.proto = proto_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			dir_q   <= 1'b0;
			dmac_q  <= '0;
			smac_q  <= '0;
			etype_q <= '0;
			vihl_q  <= '0;
			proto_q <= '0;
			sip_q   <= '0;
			dip_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (beat) begin
			dir_q   <= dir_n;
			dmac_q  <= dmac_n;
			smac_q  <= smac_n;
			etype_q <= etype_n;
			vihl_q  <= vihl_n;
			proto_q <= proto_n;
			sip_q   <= sip_n;
			dip_q   <= dip_n;
			sport_q <= sport_n;
			dport_q <= dport_n;
			if (end_of_packet)
				pos_q <= '0;
			else if (pos_q != 16'hFFFF)
				pos_q <= pos_q + 16'd1;
		end
	end

endmodule

// ----- sv/fat_table.sv -----
module fat_table
	import fat_pkg::*;
#(
	parameter int unsigned FLOWS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_done,
	input  frame_info_t frame,
	output status_t     status,
	output logic [4:0]  slot,
	output flow_stats_t stats
);

	localparam int unsigned SW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

	logic [FLOWS-1:0] valid_q;
	logic [SW-1:0]    age_q [FLOWS];
	flow_key_t        key_q [FLOWS];
	flow_stats_t      st_q  [FLOWS];

	logic [FLOWS-1:0] hit;
	logic [SW-1:0]    hit_idx, free_idx, lru_idx, sel;
	logic             found, freefound;
	logic [SW:0]      old_age;
	flow_stats_t      nst;
	logic [63:0]      len64;

	always_comb begin
		found     = 1'b0;
		freefound = 1'b0;
		hit_idx   = '0;
		free_idx  = '0;
		lru_idx   = '0;
		for (int i = 0; i < FLOWS; i++)
			hit[i] = valid_q[i] && (key_q[i] == frame.key);
		for (int i = FLOWS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found   = 1'b1;
				hit_idx = SW'(i);
			end
			if (!valid_q[i]) begin
				freefound = 1'b1;
				free_idx  = SW'(i);
			end
			if (age_q[i] == SW'(FLOWS - 1))
				lru_idx = SW'(i);
		end
		len64 = {48'd0, frame.len};
		if (found) begin
			sel          = hit_idx;
			old_age      = {1'b0, age_q[hit_idx]};
			nst          = st_q[hit_idx];
			nst.last_seen = frame.now;
			nst.packets  = st_q[hit_idx].packets + 64'd1;
			if (!frame.dir)
				nst.upload = st_q[hit_idx].upload + len64;
			else
				nst.download = st_q[hit_idx].download + len64;
		end else begin
			sel     = freefound ? free_idx : lru_idx;
			old_age = freefound ? (SW+1)'(FLOWS) : {1'b0, age_q[lru_idx]};
			nst.packets    = 64'd1;
			nst.upload     = frame.dir ? 64'd0 : len64;
			nst.download   = frame.dir ? len64 : 64'd0;
			nst.first_seen = frame.now;
			nst.last_seen  = frame.now;
		end
	end

	wire do_upd = frame_done && frame.counted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < FLOWS; i++)
				age_q[i] <= '0;
		end else if (do_upd) begin
			valid_q[sel] <= 1'b1;
			for (int i = 0; i < FLOWS; i++)
				if (SW'(i) != sel && valid_q[i] && ({1'b0, age_q[i]} < old_age))
					age_q[i] <= age_q[i] + 1'b1;
			age_q[sel] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_upd) begin
			st_q[sel] <= nst;
			if (!found)
				key_q[sel] <= frame.key;
		end
	end

	always_comb begin
		if (!frame.counted) begin
			status = ST_NONE;
			slot   = '0;
			stats  = '0;
		end else begin
			status = found ? ST_UPDATE : (freefound ? ST_NEW : ST_EVICT);
			slot   = 5'(sel);
			stats  = nst;
		end
	end

endmodule

// ----- sv/ipv4_flow_accounting_table.sv -----
// IPv4 five-tuple flow accounting table. Frame bytes enter one per beat on s_axis.
// tdata carries the byte in its low eight bits and the current time in
// nanoseconds above it, and tuser carries the direction. The direction of the
// first byte holds for the whole frame, and the time of the final byte is the
// one recorded. tlast marks the final byte. At that beat the captured headers
// are checked (IPv4, IHL 5, TCP of 54+ bytes or UDP of 42+ bytes). A
// client-oriented key is then looked up in a fully associative table of FLOWS
// entries with true-LRU replacement. One result beat with the status and the
// flow's updated statistics is registered into the output register, or into
// the skid slot while m_axis stalls. The lookup, update and age refresh all
// happen in the cycle of the final byte, so frames may follow each other back
// to back. A one-deep output register with a skid slot decouples m_axis
// backpressure. s_axis_tready drops only while a result waits in the skid slot
// behind a stalled m_axis. Status 0 beats carry zero in every other field.
module ipv4_flow_accounting_table
	import fat_pkg::*;
#(
	parameter int unsigned FLOWS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [71:0]  s_axis_tdata,  // frame byte, time stamp in ns
	input  logic         s_axis_tlast,  // final byte of the frame
	input  logic         s_axis_tuser,  // direction
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [327:0] m_axis_tdata   // status, slot, packet total,
	                                    // ingress byte total, egress byte total,
	                                    // creation time, latest time, pad
);

	logic        frame_done, beat;
	frame_info_t frame;
	status_t     status;
	logic [4:0]  slot;
	flow_stats_t stats;
	logic [326:0] res;

	logic         out_v_q, skid_v_q;
	logic [326:0] out_q, skid_q;

	// Accept while the skid slot is empty.
	assign s_axis_tready = !skid_v_q;
	assign beat = s_axis_tvalid && s_axis_tready;

	fat_parser u_parser (
		.clk, .arst_n, .beat,
		.data_byte(s_axis_tdata[7:0]), .end_of_packet(s_axis_tlast),
		.direction(s_axis_tuser), .time_ns(s_axis_tdata[71:8]),
		.frame_done, .frame
	);

	fat_table #(.FLOWS(FLOWS)) u_table (
		.clk, .arst_n, .frame_done, .frame, .status, .slot, .stats
	);

	assign res = {stats.last_seen, stats.first_seen, stats.download,
		stats.upload, stats.packets, slot, status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_axis_tready) begin
				out_v_q  <= skid_v_q || frame_done;
				skid_v_q <= 1'b0;
			end else if (frame_done) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready)
			out_q <= skid_v_q ? skid_q : res;
		else if (frame_done)
			skid_q <= res;
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, out_q};

endmodule

// ----- sv/fat_checker.sv -----
`include "ipv4_flow_accounting_table_macros.svh"
module fat_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         s_axis_tlast,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [327:0] m_axis_tdata
);
	`FAT_ASSERT_IMPL(a_none_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[1:0] == 2'd0, m_axis_tdata[327:2] == '0, "uncounted beat not zero")
	`FAT_ASSERT_NEXT(a_last_out, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, m_axis_tvalid, "no result after last byte")
	`FAT_ASSERT_IMPL(a_pkts, clk, arst_n, m_axis_tvalid && m_axis_tdata[1:0] != 2'd0, m_axis_tdata[70:7] != 64'd0 || m_axis_tdata[1:0] == 2'd2, "new flow without a packet")
	`FAT_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind ipv4_flow_accounting_table fat_checker u_fat_checker (.*);

// ----- dv/ipv4_flow_accounting_table_checker.sv -----
module ipv4_flow_accounting_table_checker
	import fat_pkg::*;
#(
	parameter int unsigned FLOWS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [71:0]  s_axis_tdata,
	input  logic         s_axis_tlast,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [327:0] m_axis_tdata,
	output int           fail_count,
	output int           pending_results,
	output int           results_seen
);

	typedef struct packed {
		status_t     status;
		logic [4:0]  slot;
		flow_stats_t stats;
	} flow_result_t;

	flow_result_t flow_results_due[$];

	logic [15:0] pos;
	logic        frame_dir;
	logic [47:0] dmac, smac;
	logic [15:0] etype, sport, dport;
	logic [7:0]  vihl, proto;
	logic [31:0] sip, dip;

	logic        valid_q [FLOWS];
	int unsigned age_q [FLOWS];
	flow_key_t   key_q [FLOWS];
	flow_stats_t stats_q [FLOWS];

	// Take one frame byte; at tlast, account the frame and queue its result.
	task automatic account_byte(input logic [7:0] b, input logic last,
			input logic dir_in, input logic [63:0] now);
		flow_result_t r;
		flow_key_t    k;
		logic [15:0]  len;
		logic         counted, found, dir;
		int unsigned  s, old_age;
		if (pos == 0) frame_dir = dir_in;
		if (pos < 6) dmac = {dmac[39:0], b};
		else if (pos < 12) smac = {smac[39:0], b};
		else if (pos < 14) etype = {etype[7:0], b};
		else if (pos == 14) vihl = b;
		else if (pos == 23) proto = b;
		else if (pos >= 26 && pos < 30) sip = {sip[23:0], b};
		else if (pos >= 30 && pos < 34) dip = {dip[23:0], b};
		else if (pos >= 34 && pos < 36) sport = {sport[7:0], b};
		else if (pos >= 36 && pos < 38) dport = {dport[7:0], b};
		len = (pos == 16'hFFFF) ? pos : pos + 16'd1;
		if (pos != 16'hFFFF) pos++;
		if (!last) return;
		pos = 0;
		r = '0;
		counted = len >= MinEth && etype == EtherIpv4 && len >= MinIp
			&& vihl[3:0] == IhlPlain
			&& ((proto == ProtoTcp && len >= MinTcp)
			|| (proto == ProtoUdp && len >= MinUdp));
		if (!counted) begin
			r.status = ST_NONE;
			flow_results_due.push_back(r);
			return;
		end
		dir = frame_dir;
		if (!dir) k = '{mac: smac, cip: sip, rip: dip, ports: {sport, dport}, proto: proto};
		else k = '{mac: dmac, cip: dip, rip: sip, ports: {dport, sport}, proto: proto};
		found = 0;
		s = 0;
		for (int i = 0; i < FLOWS; i++) begin
			if (!found && valid_q[i] && key_q[i] == k) begin
				found = 1;
				s = i;
			end
		end
		if (found) begin
			old_age = age_q[s];
			stats_q[s].last_seen = now;
			stats_q[s].packets += 1;
			if (!dir) stats_q[s].upload += len;
			else stats_q[s].download += len;
			r.status = ST_UPDATE;
		end else begin
			r.status = ST_EVICT;
			for (int i = FLOWS - 1; i >= 0; i--) begin
				if (!valid_q[i]) begin
					s = i;
					r.status = ST_NEW;
				end
			end
			if (r.status == ST_NEW) old_age = FLOWS;
			else begin
				s = 0;
				for (int i = 1; i < FLOWS; i++) if (age_q[i] > age_q[s]) s = i;
				old_age = age_q[s];
			end
			valid_q[s] = 1;
			key_q[s] = k;
			stats_q[s] = '{packets: 64'd1, upload: dir ? 64'd0 : 64'(len),
				download: dir ? 64'(len) : 64'd0, first_seen: now,
				last_seen: now};
		end
		for (int i = 0; i < FLOWS; i++)
			if (i != s && valid_q[i] && age_q[i] < old_age) age_q[i]++;
		age_q[s] = 0;
		r.slot = s[4:0];
		r.stats = stats_q[s];
		flow_results_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		flow_result_t want, got;
		if (!arst_n) begin
			pos = 0;
			frame_dir = 0;
			{dmac, smac, etype, vihl, proto, sip, dip, sport, dport} = '0;
			for (int i = 0; i < FLOWS; i++) begin
				valid_q[i] = 0;
				age_q[i] = 0;
			end
			flow_results_due.delete();
			fail_count <= 0;
			results_seen <= 0;
			pending_results <= 0;
		end else begin
			// Check the result first: it can only stem from an earlier frame.
			if (m_axis_tvalid && m_axis_tready) begin
				got.status           = status_t'(m_axis_tdata[1:0]);
				got.slot             = m_axis_tdata[6:2];
				got.stats.packets    = m_axis_tdata[70:7];
				got.stats.upload     = m_axis_tdata[134:71];
				got.stats.download   = m_axis_tdata[198:135];
				got.stats.first_seen = m_axis_tdata[262:199];
				got.stats.last_seen  = m_axis_tdata[326:263];
				results_seen <= results_seen + 1;
				if (flow_results_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = flow_results_due.pop_front();
					if (got !== want) begin
						if (fail_count < 10) begin
							$display({"mismatch: expected st=%0d slot=%0d pk=%0d up=%0d",
								" dn=%0d fs=%0d ls=%0d"},
								want.status, want.slot, want.stats.packets,
								want.stats.upload, want.stats.download,
								want.stats.first_seen, want.stats.last_seen);
							$display({"          got      st=%0d slot=%0d pk=%0d up=%0d",
								" dn=%0d fs=%0d ls=%0d"},
								got.status, got.slot, got.stats.packets,
								got.stats.upload, got.stats.download,
								got.stats.first_seen, got.stats.last_seen);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				account_byte(s_axis_tdata[7:0], s_axis_tlast, s_axis_tuser,
					s_axis_tdata[71:8]);
			pending_results <= flow_results_due.size();
		end
	end

endmodule

// ----- dv/tb_ipv4_flow_accounting_table.sv -----
module tb_ipv4_flow_accounting_table
	import fat_pkg::*;
();

	localparam int unsigned FLOWS = 32;
	localparam int RUN_LIMIT = 60000;
	localparam int BYTE_TARGET = 1250;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata = '0;   // frame byte, time stamp in ns
	logic         s_axis_tlast = 0;
	logic         s_axis_tuser = 0;    // direction
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [327:0] m_axis_tdata;
	int           fail_count, pending_results, results_seen;
	int           cycle_count = 0;
	int           frames_sent = 0, bytes_sent = 0;

	// Small pools of addresses so that flows repeat and hit.
	logic [47:0] mac_pool [4];
	logic [31:0] ip_pool [6];
	logic [15:0] port_pool [5];
	logic [63:0] now_ns = 64'd1000;
	logic [7:0]  frame_q [$];

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	ipv4_flow_accounting_table #(.FLOWS(FLOWS)) i_dut (.*);

	ipv4_flow_accounting_table_checker #(.FLOWS(FLOWS)) i_checker (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver stall pattern: phases of always-ready, and of random stalls.
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(10, 80)) begin
				@(negedge clk);
				m_axis_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= mode);
			end
		end
	end

	// Build a frame into frame_q. kind: 0 TCP, 1 UDP, 2 random garbage.
	task automatic build_frame(input int kind, input int len, input bit dir,
			input int flow_pick);
		logic [47:0] cmac, rmac;
		logic [31:0] cip, rip;
		logic [15:0] cport, rport;
		logic [47:0] d_mac, s_mac;
		logic [31:0] s_ip, d_ip;
		logic [15:0] s_port, d_port;
		frame_q.delete();
		cmac = mac_pool[flow_pick % 4];
		rmac = mac_pool[(flow_pick / 4) % 4];
		cip = ip_pool[flow_pick % 3];
		rip = ip_pool[3 + (flow_pick / 3) % 3];
		cport = port_pool[flow_pick % 5];
		rport = port_pool[(flow_pick / 5) % 5];
		if (!dir) {d_mac, s_mac, s_ip, d_ip, s_port, d_port} = {rmac, cmac, cip, rip, cport, rport};
		else {d_mac, s_mac, s_ip, d_ip, s_port, d_port} = {cmac, rmac, rip, cip, rport, cport};
		for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
		if (kind == 2) return;
		for (int i = 0; i < 6 && i < len; i++) frame_q[i] = d_mac[47 - 8 * i -: 8];
		for (int i = 0; i < 6 && i + 6 < len; i++) frame_q[i + 6] = s_mac[47 - 8 * i -: 8];
		if (len > 13) begin
			frame_q[12] = EtherIpv4[15:8];
			frame_q[13] = EtherIpv4[7:0];
		end
		if (len > 14) frame_q[14] = {4'($urandom), IhlPlain};
		if (len > 23) frame_q[23] = kind ? ProtoUdp : ProtoTcp;
		for (int i = 0; i < 4 && i + 26 < len; i++) frame_q[i + 26] = s_ip[31 - 8 * i -: 8];
		for (int i = 0; i < 4 && i + 30 < len; i++) frame_q[i + 30] = d_ip[31 - 8 * i -: 8];
		if (len > 35) begin
			frame_q[34] = s_port[15:8];
			frame_q[35] = s_port[7:0];
		end
		if (len > 37) begin
			frame_q[36] = d_port[15:8];
			frame_q[37] = d_port[7:0];
		end
	endtask

	// Send frame_q in bursts with random gaps; no_gaps keeps tvalid high throughout.
	task automatic send_frame(input bit dir, input logic [63:0] stamp, input bit no_gaps);
		int burst;
		burst = 0;
		foreach (frame_q[i]) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if (!no_gaps && $urandom_range(0, 2) == 0) begin
					s_axis_tvalid <= 0;
					repeat ($urandom_range(1, 6)) @(negedge clk);
				end
			end
			burst--;
			s_axis_tvalid <= 1;
			s_axis_tdata <= {(i == frame_q.size() - 1) ? stamp : {$urandom, $urandom},
				frame_q[i]};
			s_axis_tlast <= (i == frame_q.size() - 1);
			s_axis_tuser <= (i == 0) ? dir : 1'($urandom);
			@(posedge clk);
			while (!s_axis_tready) @(posedge clk);
			@(negedge clk);
			bytes_sent++;
		end
		frames_sent++;
	endtask

	task automatic frame_out(input int kind, input int len, input bit dir,
			input int flow_pick, input logic [63:0] stamp);
		build_frame(kind, len, dir, flow_pick);
		send_frame(dir, stamp, $urandom_range(0, 3) == 0);
	endtask

	// Special frames: wrong ethertype, wrong IHL, other protocol.
	task automatic broken_frame(input int which);
		build_frame(1, 42, 0, 1);
		case (which)
			0: frame_q[12] = 8'h86;
			1: frame_q[14] = 8'h46;
			default: frame_q[23] = 8'd1;
		endcase
		send_frame(0, now_ns, 0);
	endtask

	initial begin
		int kind, len, pick;
		for (int i = 0; i < 4; i++) mac_pool[i] = 48'({$urandom, $urandom});
		mac_pool[0] = '1;
		ip_pool[0] = '1;
		ip_pool[1] = '0;
		for (int i = 2; i < 6; i++) ip_pool[i] = $urandom;
		port_pool[0] = '1;
		port_pool[1] = '0;
		for (int i = 2; i < 5; i++) port_pool[i] = 16'($urandom);
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: length edges, both directions, broken headers, time extremes.
		frame_out(0, 54, 0, 0, 64'd0);
		frame_out(0, 54, 1, 0, '1);
		frame_out(0, 53, 0, 0, now_ns);
		frame_out(1, 42, 0, 7, now_ns);
		frame_out(1, 41, 1, 7, now_ns);
		frame_out(1, 34, 0, 7, now_ns);
		frame_out(1, 13, 0, 7, now_ns);
		frame_out(2, 1, 0, 7, now_ns);
		frame_out(0, 14, 0, 7, now_ns);
		for (int i = 0; i < 3; i++) broken_frame(i);
		frame_out(1, 60, 0, 9, 64'h8000_0000_0000_0000);

		// Random: mostly well-formed frames over a small pool of flows.
		while (bytes_sent < BYTE_TARGET) begin
			kind = $urandom_range(0, 9);
			kind = (kind < 4) ? 0 : (kind < 9) ? 1 : 2;
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 41) : $urandom_range(42, 64);
			pick = $urandom_range(0, 11);
			now_ns += $urandom_range(1, 100000);
			if ($urandom_range(0, 15) == 0) broken_frame($urandom_range(0, 2));
			else frame_out(kind, len, 1'($urandom), pick, now_ns);
		end
		s_axis_tvalid <= 0;

		while (pending_results != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d frames (%0d bytes) drawn from %0d client flows in both directions;",
			frames_sent, bytes_sent, 12);
		$display("%0d result beats compared under random source gaps and sink stalls.",
			results_seen);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/fat_pkg.sv
sv/fat_parser.sv
sv/fat_table.sv
sv/ipv4_flow_accounting_table.sv
sv/fat_checker.sv
dv/ipv4_flow_accounting_table_checker.sv
dv/tb_ipv4_flow_accounting_table.sv
